### rtl/core/block_free_list_allocator_unit_assert.svh
// Assertion macros for the free-list allocator, clocked on clk, held off in reset
`ifndef BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define BFLA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication
`define BFLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

### rtl/core/bfla_pkg.sv
// Shared types and constants of the free-list allocator
package bfla_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int LINK_W     = IDX_W + 1;
	localparam int CFG_W      = 11;

	typedef logic [1:0]        func_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [CFG_W-1:0]  cfg_t;

	// operation codes
	localparam func_t FUNC_INIT  = 2'd0;
	localparam func_t FUNC_ALLOC = 2'd1;
	localparam func_t FUNC_FREE  = 2'd2;

	localparam cfg_t  CFG_RESET  = cfg_t'(MAX_BLOCKS);

endpackage

### rtl/core/bfla_link_ram.sv
// Simple dual-port link memory: one write port, one registered read port
module bfla_link_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/block_free_list_allocator_unit.sv
// Fixed-block allocator keeping a singly linked free list in a link memory
//
// Usage:
//   Command channel: a word (func, ret_index) is taken on a clock edge where
//   start is high and busy is low. func selects init, alloc or free.
//   Result channel: done pulses for one cycle with ok and block_index. The
//   receiver cannot hold results off; each word is taken as it appears.
//   Config: cfg_we writes cfg_wdata into blocks_in_use (block count, block 0
//   is the null link, never handed out); write it only while no command is outstanding.
// Timing:
//   Free, func 3 and any alloc that fails: result registered in the next cycle,
//   busy stays low, so such commands can issue every cycle.
//   Successful alloc: the command passes through ALLOC_WAIT before its result;
//   busy is high for one cycle while the popped block's link is read from the link memory.
//   Init: walks all 1024 link entries, one memory write a cycle; the result
//   is registered with the last entry's write, and busy is high throughout.
// Reset: the list is empty (head link 0), blocks_in_use is 1024; the link
//   memory holds no defined value until an init has run.
module block_free_list_allocator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bfla_pkg::func_t func,
	input  bfla_pkg::idx_t  ret_index,
	input  logic            cfg_we,
	input  bfla_pkg::cfg_t  cfg_wdata,
	output logic            done,
	output logic            ok,
	output bfla_pkg::idx_t  block_index
);
	import bfla_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC_WAIT,
		ST_INIT_RUN
	} state_t;

	state_t state_q;
	link_t  head_q;
	idx_t   init_cnt_q;
	cfg_t   blocks_in_use_q;
	logic   done_q;
	logic   ok_q;
	idx_t   block_index_q;

	logic   accept;
	link_t  n_blocks;
	logic   head_ok;
	logic   free_ok;
	logic   ram_we;
	idx_t   ram_waddr;
	link_t  ram_wdata;
	logic   ram_re;
	link_t  ram_rdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= CFG_RESET;
		end else if (cfg_we) begin
			blocks_in_use_q <= cfg_wdata;
		end
	end

	// block count clamped to memory depth, and command checks
	always_comb begin
		accept   = start && (state_q == ST_IDLE);
		n_blocks = (blocks_in_use_q > CFG_RESET) ? link_t'(MAX_BLOCKS)
		                                         : link_t'(blocks_in_use_q);
		head_ok  = (head_q != '0) && (head_q < n_blocks);
		free_ok  = (ret_index != '0) && ({1'b0, ret_index} < n_blocks);
	end

	// link memory port control: init sweep or free push on write, alloc on read
	always_comb begin
		ram_re    = accept && (func == FUNC_ALLOC) && head_ok;
		ram_we    = 1'b0;
		ram_waddr = init_cnt_q;
		ram_wdata = '0;
		if (state_q == ST_INIT_RUN) begin
			ram_we    = 1'b1;
			ram_wdata = ({1'b0, init_cnt_q} < n_blocks) ? ({1'b0, init_cnt_q} + link_t'(1))
			                                            : '0;
		end else if (accept && (func == FUNC_FREE) && free_ok) begin
			ram_we    = 1'b1;
			ram_waddr = ret_index;
			ram_wdata = head_q;
		end
	end

	bfla_link_ram #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (LINK_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// sequencer, head link and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= '0;
			init_cnt_q    <= '0;
			done_q        <= 1'b0;
			ok_q          <= 1'b0;
			block_index_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_INIT: begin
								state_q    <= ST_INIT_RUN;
								init_cnt_q <= '0;
							end
							FUNC_ALLOC: begin
								if (head_ok) begin
									state_q <= ST_ALLOC_WAIT;
								end else begin
									done_q        <= 1'b1;
									ok_q          <= 1'b0;
									block_index_q <= '0;
								end
							end
							FUNC_FREE: begin
								done_q        <= 1'b1;
								ok_q          <= free_ok;
								block_index_q <= '0;
								if (free_ok) begin
									head_q <= {1'b0, ret_index};
								end
							end
							default: begin
								done_q        <= 1'b1;
								ok_q          <= 1'b0;
								block_index_q <= '0;
							end
						endcase
					end
				end
				ST_ALLOC_WAIT: begin
					// popped block's link is now on the read port
					head_q        <= ram_rdata;
					done_q        <= 1'b1;
					ok_q          <= 1'b1;
					block_index_q <= head_q[IDX_W-1:0];
					state_q       <= ST_IDLE;
				end
				ST_INIT_RUN: begin
					init_cnt_q <= init_cnt_q + idx_t'(1);
					if (init_cnt_q == idx_t'(MAX_BLOCKS - 1)) begin
						head_q        <= link_t'(1);
						done_q        <= 1'b1;
						ok_q          <= 1'b1;
						block_index_q <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign ok          = ok_q;
	assign block_index = block_index_q;

	`include "block_free_list_allocator_unit_assert.svh"

	// a result word never overlaps a busy cycle
	`BFLA_ASSERT_NOW(a_done_not_busy, done, !busy)
	// a nonzero block index only comes with success
	`BFLA_ASSERT_NOW(a_index_ok, done && (block_index != '0), ok)
	// a valid alloc holds the channel for the memory read
	`BFLA_ASSERT_NEXT(a_alloc_busy, accept && (func == FUNC_ALLOC) && head_ok, busy && !done)
	// an accepted free pushes the block onto the head
	`BFLA_ASSERT_NEXT(a_free_head, accept && (func == FUNC_FREE) && free_ok,
		done && ok && (head_q == {1'b0, $past(ret_index)}))
	// init keeps the channel busy
	`BFLA_ASSERT_NEXT(a_init_busy, accept && (func == FUNC_INIT), busy && !done)

endmodule
